[rtl/mvc_pkg.sv]
package mvc_pkg;

    localparam int DEF_SAMPLE_WIDTH     = 16;
    localparam int DEF_MATRIX_FRAC_BITS = 14;
    localparam int DEF_GAIN_FRAC_BITS   = 12;

    // three packed signed 16-bit lanes per register
    localparam int LANE_W = 16;
    localparam int REG_W  = 48;

    // APB side: 64-bit data, registers on 8-byte boundaries
    localparam int DATA_W = 64;
    localparam int ADDR_W = 6;

    // guard on the row-sum, gain-shift and column-sum stages: +-(2^44 - 1)
    localparam longint STAGE_LIMIT = 64'h0000_0FFF_FFFF_FFFF;

    localparam logic [REG_W-1:0] OFFSET_RST = 48'h0000_0000_0000;
    localparam logic [REG_W-1:0] GAIN_RST   = 48'h1000_1000_1000;
    localparam logic [REG_W-1:0] ROW0_RST   = 48'h0000_0000_4000;
    localparam logic [REG_W-1:0] ROW1_RST   = 48'h0000_4000_0000;
    localparam logic [REG_W-1:0] ROW2_RST   = 48'h4000_0000_0000;

    typedef enum logic [2:0] {
        REG_OFFSET = 3'd0,
        REG_GAIN   = 3'd1,
        REG_ROW0   = 3'd2,
        REG_ROW1   = 3'd3,
        REG_ROW2   = 3'd4
    } cfg_reg_t;

endpackage

[rtl/magnetometer_vector_calibration.sv]
// Throughput: one sample per cycle while the output is not stalled; eight register stages
// (offset, matrix products, row sum, gain product, gain shift, transpose products, column sum, saturate).
// A stalled output holds only the stages behind it that are full; bubbles close up.
// Reset (rst_n low, asynchronous) empties the pipeline and loads unity gains,
// zero offsets and the identity matrix.
module magnetometer_vector_calibration #(
    parameter int SAMPLE_WIDTH     = mvc_pkg::DEF_SAMPLE_WIDTH,
    parameter int MATRIX_FRAC_BITS = mvc_pkg::DEF_MATRIX_FRAC_BITS,
    parameter int GAIN_FRAC_BITS   = mvc_pkg::DEF_GAIN_FRAC_BITS
) (
    input  logic                              clk,
    input  logic                              rst_n,

    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [mvc_pkg::ADDR_W-1:0]        paddr,
    input  logic [mvc_pkg::DATA_W-1:0]        pwdata,
    output logic [mvc_pkg::DATA_W-1:0]        prdata,
    output logic                              pready,

    input  logic                              sample_valid,
    output logic                              sample_ready,
    input  logic signed [SAMPLE_WIDTH-1:0]    raw_x,
    input  logic signed [SAMPLE_WIDTH-1:0]    raw_y,
    input  logic signed [SAMPLE_WIDTH-1:0]    raw_z,

    output logic                              cal_valid,
    input  logic                              cal_ready,
    output logic signed [SAMPLE_WIDTH-1:0]    cal_x,
    output logic signed [SAMPLE_WIDTH-1:0]    cal_y,
    output logic signed [SAMPLE_WIDTH-1:0]    cal_z,
    output logic                              clipped
);

    import mvc_pkg::*;

    localparam int NSTG = 8;
    localparam int LIMW = 46;

    // difference
    localparam int DW   = ((SAMPLE_WIDTH > LANE_W) ? SAMPLE_WIDTH : LANE_W) + 1;
    // forward rotation
    localparam int P1W  = DW + LANE_W;
    localparam int A1W  = P1W + 2;
    localparam int SH1W = ((A1W - MATRIX_FRAC_BITS) > 1) ? (A1W - MATRIX_FRAC_BITS) : 1;
    localparam int EW1  = (SH1W > LIMW) ? SH1W : LIMW;
    localparam int RW   = (SH1W < LIMW - 1) ? SH1W : LIMW - 1;
    // gain
    localparam int P2W  = RW + LANE_W;
    localparam int SH2W = ((P2W - GAIN_FRAC_BITS) > 1) ? (P2W - GAIN_FRAC_BITS) : 1;
    localparam int EW2  = (SH2W > LIMW) ? SH2W : LIMW;
    localparam int SVW  = (SH2W < LIMW - 1) ? SH2W : LIMW - 1;
    // back rotation
    localparam int P3W  = SVW + LANE_W;
    localparam int A3W  = P3W + 2;
    localparam int SH3W = ((A3W - MATRIX_FRAC_BITS) > 1) ? (A3W - MATRIX_FRAC_BITS) : 1;
    localparam int EW3  = (SH3W > LIMW) ? SH3W : LIMW;
    localparam int BW   = (SH3W < LIMW - 1) ? SH3W : LIMW - 1;
    // output saturation
    localparam int XW   = ((BW > SAMPLE_WIDTH) ? BW : SAMPLE_WIDTH) + 1;

    localparam logic signed [EW1-1:0] LIM1 = EW1'(STAGE_LIMIT);
    localparam logic signed [EW2-1:0] LIM2 = EW2'(STAGE_LIMIT);
    localparam logic signed [EW3-1:0] LIM3 = EW3'(STAGE_LIMIT);
    localparam logic signed [XW-1:0]  OUT_HI =
        XW'((longint'(1) <<< (SAMPLE_WIDTH - 1)) - longint'(1));
    localparam logic signed [XW-1:0]  OUT_LO = ~OUT_HI;

    // ---------------- configuration registers ----------------
    logic [REG_W-1:0] offset_reg;
    logic [REG_W-1:0] gain_reg;
    logic [REG_W-1:0] row0_reg;
    logic [REG_W-1:0] row1_reg;
    logic [REG_W-1:0] row2_reg;
    logic             cfg_wr;
    cfg_reg_t         cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = cfg_reg_t'(paddr[ADDR_W-1:3]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg <= OFFSET_RST;
            gain_reg   <= GAIN_RST;
            row0_reg   <= ROW0_RST;
            row1_reg   <= ROW1_RST;
            row2_reg   <= ROW2_RST;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_OFFSET: offset_reg <= pwdata[REG_W-1:0];
                REG_GAIN:   gain_reg   <= pwdata[REG_W-1:0];
                REG_ROW0:   row0_reg   <= pwdata[REG_W-1:0];
                REG_ROW1:   row1_reg   <= pwdata[REG_W-1:0];
                REG_ROW2:   row2_reg   <= pwdata[REG_W-1:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            REG_OFFSET: prdata = DATA_W'(offset_reg);
            REG_GAIN:   prdata = DATA_W'(gain_reg);
            REG_ROW0:   prdata = DATA_W'(row0_reg);
            REG_ROW1:   prdata = DATA_W'(row1_reg);
            REG_ROW2:   prdata = DATA_W'(row2_reg);
            default:    prdata = '0;
        endcase
    end

    // unpack lanes
    logic        [REG_W-1:0]  row  [3];
    logic signed [LANE_W-1:0] mat  [3][3];
    logic signed [LANE_W-1:0] off  [3];
    logic signed [LANE_W-1:0] gain [3];
    logic signed [SAMPLE_WIDTH-1:0] raw [3];

    assign row[0] = row0_reg;
    assign row[1] = row1_reg;
    assign row[2] = row2_reg;
    assign raw[0] = raw_x;
    assign raw[1] = raw_y;
    assign raw[2] = raw_z;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            off[i]  = offset_reg[LANE_W*i +: LANE_W];
            gain[i] = gain_reg[LANE_W*i +: LANE_W];
            for (int j = 0; j < 3; j++)
                mat[i][j] = row[i][LANE_W*j +: LANE_W];
        end
    end

    // ---------------- stage handshake ----------------
    logic [NSTG-1:0] valid_reg;
    logic [NSTG-1:0] valid_next;
    logic [NSTG-1:0] valid_in;
    logic [NSTG-1:0] stg_ready;

    assign valid_in = {valid_reg[NSTG-2:0], sample_valid};

    always_comb
    begin
        stg_ready[NSTG-1] = !valid_reg[NSTG-1] || cal_ready;
        for (int k = NSTG - 2; k >= 0; k--)
            stg_ready[k] = !valid_reg[k] || stg_ready[k+1];
        for (int k = 0; k < NSTG; k++)
            valid_next[k] = stg_ready[k] ? valid_in[k] : valid_reg[k];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= valid_next;
    end

    assign sample_ready = stg_ready[0];
    assign cal_valid    = valid_reg[NSTG-1];

    // ---------------- datapath ----------------
    logic signed [DW-1:0]           d_reg  [3];
    logic signed [DW-1:0]           d_next [3];
    logic signed [P1W-1:0]          p1_reg  [3][3];
    logic signed [P1W-1:0]          p1_next [3][3];
    logic signed [RW-1:0]           r_reg  [3];
    logic signed [RW-1:0]           r_next [3];
    logic signed [P2W-1:0]          p2_reg  [3];
    logic signed [P2W-1:0]          p2_next [3];
    logic signed [SVW-1:0]          s_reg  [3];
    logic signed [SVW-1:0]          s_next [3];
    logic signed [P3W-1:0]          p3_reg  [3][3];
    logic signed [P3W-1:0]          p3_next [3][3];
    logic signed [BW-1:0]           b_reg  [3];
    logic signed [BW-1:0]           b_next [3];
    logic signed [SAMPLE_WIDTH-1:0] cal_reg  [3];
    logic signed [SAMPLE_WIDTH-1:0] cal_next [3];
    logic                           clip_reg;
    logic                           clip_next;

    // stage 0: remove hard-iron offset
    always_comb
    begin
        for (int i = 0; i < 3; i++)
            d_next[i] = DW'(raw[i]) - DW'(off[i]);
    end

    // stage 1: forward rotation products
    always_comb
    begin
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                p1_next[i][j] = mat[i][j] * d_reg[j];
    end

    // stage 2: row sums, floor shift, guard clamp
    always_comb
    begin
        logic signed [A1W-1:0] acc;
        logic signed [A1W-1:0] shf;
        logic signed [EW1-1:0] ext;
        for (int i = 0; i < 3; i++)
        begin
            acc = A1W'(p1_reg[i][0]) + A1W'(p1_reg[i][1]) + A1W'(p1_reg[i][2]);
            shf = acc >>> MATRIX_FRAC_BITS;
            ext = EW1'(SH1W'(shf));
            if (ext > LIM1)
                ext = LIM1;
            else if (ext < -LIM1)
                ext = -LIM1;
            r_next[i] = RW'(ext);
        end
    end

    // stage 3: per-axis gain products
    always_comb
    begin
        for (int i = 0; i < 3; i++)
            p2_next[i] = gain[i] * r_reg[i];
    end

    // stage 4: gain shift and clamp
    always_comb
    begin
        logic signed [P2W-1:0] shf;
        logic signed [EW2-1:0] ext;
        for (int i = 0; i < 3; i++)
        begin
            shf = p2_reg[i] >>> GAIN_FRAC_BITS;
            ext = EW2'(SH2W'(shf));
            if (ext > LIM2)
                ext = LIM2;
            else if (ext < -LIM2)
                ext = -LIM2;
            s_next[i] = SVW'(ext);
        end
    end

    // stage 5: transpose products, p3[i][j] = M[j][i] * s[j]
    always_comb
    begin
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                p3_next[i][j] = mat[j][i] * s_reg[j];
    end

    // stage 6: column sums, floor shift, guard clamp
    always_comb
    begin
        logic signed [A3W-1:0] acc;
        logic signed [A3W-1:0] shf;
        logic signed [EW3-1:0] ext;
        for (int i = 0; i < 3; i++)
        begin
            acc = A3W'(p3_reg[i][0]) + A3W'(p3_reg[i][1]) + A3W'(p3_reg[i][2]);
            shf = acc >>> MATRIX_FRAC_BITS;
            ext = EW3'(SH3W'(shf));
            if (ext > LIM3)
                ext = LIM3;
            else if (ext < -LIM3)
                ext = -LIM3;
            b_next[i] = BW'(ext);
        end
    end

    // stage 7: saturate to sample width
    always_comb
    begin
        logic signed [XW-1:0] xv;
        clip_next = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            xv = XW'(b_reg[i]);
            if (xv > OUT_HI)
            begin
                xv        = OUT_HI;
                clip_next = 1'b1;
            end
            else if (xv < OUT_LO)
            begin
                xv        = OUT_LO;
                clip_next = 1'b1;
            end
            cal_next[i] = SAMPLE_WIDTH'(xv);
        end
    end

    always_ff @(posedge clk)
    begin
        if (stg_ready[0])
            d_reg <= d_next;
        if (stg_ready[1])
            p1_reg <= p1_next;
        if (stg_ready[2])
            r_reg <= r_next;
        if (stg_ready[3])
            p2_reg <= p2_next;
        if (stg_ready[4])
            s_reg <= s_next;
        if (stg_ready[5])
            p3_reg <= p3_next;
        if (stg_ready[6])
            b_reg <= b_next;
        if (stg_ready[7])
        begin
            cal_reg  <= cal_next;
            clip_reg <= clip_next;
        end
    end

    assign cal_x   = cal_reg[0];
    assign cal_y   = cal_reg[1];
    assign cal_z   = cal_reg[2];
    assign clipped = clip_reg;

    // ---------------- checks ----------------
    logic acc_in;
    logic acc_out;

    assign acc_in  = sample_valid && sample_ready;
    assign acc_out = cal_valid && cal_ready;

    // an empty output stage means every stage can move
    a_empty_out_takes: assert property (@(posedge clk) disable iff (!rst_n)
        !valid_reg[NSTG-1] |-> sample_ready)
        else $error("input stalled behind an empty output stage");

    // requests in flight track accepts on both sides
    a_occupancy: assert property (@(posedge clk) disable iff (!rst_n)
        $past(rst_n) |-> ($countones(valid_reg) ==
            $past($countones(valid_reg)) + int'($past(acc_in)) - int'($past(acc_out))))
        else $error("request lost or duplicated in pipeline");

    // clip flag only with at least one axis at a rail
    a_clip_rail: assert property (@(posedge clk) disable iff (!rst_n)
        (cal_valid && clipped) |->
            (cal_x == SAMPLE_WIDTH'(OUT_HI) || cal_x == SAMPLE_WIDTH'(OUT_LO) ||
             cal_y == SAMPLE_WIDTH'(OUT_HI) || cal_y == SAMPLE_WIDTH'(OUT_LO) ||
             cal_z == SAMPLE_WIDTH'(OUT_HI) || cal_z == SAMPLE_WIDTH'(OUT_LO)))
        else $error("clipped set with no saturated axis");

endmodule
